@@ src/calm_pkg.sv @@
// Package for the joystick axis calibration block.
// Holds widths, sizes, register codes, shared types and the state enum.
// No dependencies.
`default_nettype none

package calm_pkg;

  localparam int ADC_BITS = 12;
  localparam int SAMPLES  = 16;
  localparam int CENTER   = 512;
  localparam int OUT_MAX  = 1023;
  localparam int POS_W    = 10;

  localparam int CNT_W     = $clog2(SAMPLES + 1);
  localparam int MED_IDX   = SAMPLES / 2;
  localparam int DIV_W     = ADC_BITS + $clog2(CENTER + 1);
  localparam int DCNT_W    = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 8;

  typedef logic [ADC_BITS-1:0]  adc_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [DIV_W-1:0]     quo_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INITIAL_MIN = cfg_idx_t'(0);
  localparam cfg_idx_t REG_INITIAL_MAX = cfg_idx_t'(1);

  // What one sorting cell hands to its right-hand neighbor.
  typedef struct packed {
    logic gt;
    adc_t value;
  } cell_link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } calm_state_e;

endpackage

`default_nettype wire

@@ src/calm_ifs.sv @@
// Stream interfaces of the calibration block: sample input, result output
// and configuration write channel. Depends on calm_pkg.
`default_nettype none

interface calm_in_if;
  import calm_pkg::*;
  logic valid;
  logic ready;
  adc_t adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface calm_out_if;
  import calm_pkg::*;
  logic valid;
  logic ready;
  pos_t position;
  logic center_ready;
  modport source (output valid, output position, output center_ready, input ready);
  modport sink (input valid, input position, input center_ready, output ready);
endinterface

interface calm_cfg_if;
  import calm_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  adc_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/axis_calibrate_median_center.sv @@
// Joystick axis calibration with a median center; one position per sample word.
// A sample on or past a bound passes ST_LOAD, ST_EVAL and ST_FIN; others also
// pass ST_DIV, where the serial divider yields one of 22 quotient bits a cycle.
// Words are taken only in ST_IDLE; the result register lets the next word in
// while a finished result waits. Reset loads bounds 0 and 4095, clears the
// sample count and center; the sorting cells are filled before they are read.
`default_nettype none

module axis_calibrate_median_center (
  input  wire      clk_i,
  input  wire      rst_ni,
  calm_cfg_if.sink cfg_i,
  calm_in_if.sink  sample_i,
  calm_out_if.source result_o
);
  import calm_pkg::*;

  calm_state_e state_q, state_d;

  adc_t init_min_q, init_min_d;
  adc_t init_max_q, init_max_d;
  adc_t min_q, min_d;
  adc_t max_q, max_d;
  adc_t center_q, center_d;
  cnt_t count_q, count_d;
  logic fix_q, fix_d;
  adc_t s_q, s_d;
  logic neg_q, neg_d;
  logic use_div_q, use_div_d;
  pos_t res_q, res_d;

  logic out_valid_q, out_valid_d;
  pos_t out_pos_q, out_pos_d;
  logic out_rdy_q, out_rdy_d;

  logic in_fire, cfg_fire, insert;
  adc_t median;
  adc_t offset, span;
  quo_t dividend;
  adc_t divisor;
  logic div_start, div_done;
  quo_t quotient;
  pos_t q_low;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign cfg_fire       = cfg_i.valid && cfg_i.ready;
  assign insert         = in_fire && (count_q < cnt_t'(SAMPLES));

  assign result_o.valid        = out_valid_q;
  assign result_o.position     = out_pos_q;
  assign result_o.center_ready = out_rdy_q;

  calm_sort_chain u_chain (
    .clk_i    (clk_i),
    .insert_i (insert),
    .sample_i (sample_i.adc_sample),
    .count_i  (count_q),
    .median_o (median)
  );

  // Offset and span of the side of the center that the sample falls on.
  always_comb begin
    if (s_q >= center_q) begin
      offset = s_q - center_q;
      span   = max_q - center_q;
    end else begin
      offset = center_q - s_q;
      span   = center_q - min_q;
    end
    dividend = (span == '0) ? '0 : quo_t'(offset) * quo_t'(CENTER);
    divisor  = (span == '0) ? adc_t'(1) : span;
  end

  calm_div_serial u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign q_low = quotient[POS_W-1:0];

  always_comb begin
    state_d     = state_q;
    init_min_d  = init_min_q;
    init_max_d  = init_max_q;
    min_d       = min_q;
    max_d       = max_q;
    center_d    = center_q;
    count_d     = count_q;
    fix_d       = fix_q;
    s_d         = s_q;
    neg_d       = neg_q;
    use_div_d   = use_div_q;
    res_d       = res_q;
    out_pos_d   = out_pos_q;
    out_rdy_d   = out_rdy_q;
    out_valid_d = out_valid_q && !result_o.ready;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          s_d     = sample_i.adc_sample;
          fix_d   = 1'b0;
          if (insert) begin
            count_d  = count_q + cnt_t'(1);
            center_d = sample_i.adc_sample;
            fix_d    = (count_q == cnt_t'(SAMPLES - 1));
          end
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // The chain now holds the full set when this sample filled it.
        if (fix_q) begin
          center_d = median;
        end
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        neg_d = (s_q < center_q);
        if (s_q >= max_q) begin
          max_d     = s_q;
          res_d     = pos_t'(OUT_MAX);
          use_div_d = 1'b0;
          state_d   = ST_FIN;
        end else if (s_q <= min_q) begin
          min_d     = s_q;
          res_d     = '0;
          use_div_d = 1'b0;
          state_d   = ST_FIN;
        end else begin
          use_div_d = 1'b1;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_rdy_d   = (count_q >= cnt_t'(SAMPLES));
          if (!use_div_q) begin
            out_pos_d = res_q;
          end else if (neg_q) begin
            out_pos_d = pos_t'(CENTER) - q_low;
          end else begin
            out_pos_d = pos_t'(CENTER) + q_low;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A write to either bound register restarts calibration from the new bounds.
    if (cfg_fire && (cfg_i.index == REG_INITIAL_MIN || cfg_i.index == REG_INITIAL_MAX)) begin
      if (cfg_i.index == REG_INITIAL_MIN) begin
        init_min_d = cfg_i.data;
      end else begin
        init_max_d = cfg_i.data;
      end
      min_d    = init_min_d;
      max_d    = init_max_d;
      center_d = '0;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      init_min_q  <= '0;
      init_max_q  <= adc_t'(4095);
      min_q       <= '0;
      max_q       <= adc_t'(4095);
      center_q    <= '0;
      count_q     <= '0;
      fix_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_min_q  <= init_min_d;
      init_max_q  <= init_max_d;
      min_q       <= min_d;
      max_q       <= max_d;
      center_q    <= center_d;
      count_q     <= count_d;
      fix_q       <= fix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    neg_q     <= neg_d;
    use_div_q <= use_div_d;
    res_q     <= res_d;
    out_pos_q <= out_pos_d;
    out_rdy_q <= out_rdy_d;
  end

endmodule

`default_nettype wire

@@ src/calm_sort_cell.sv @@
// One cell of the insertion sorting chain: holds one stored sample.
// Depends on calm_pkg.
`default_nettype none

module calm_sort_cell (
  input  wire                    clk_i,
  input  wire                    insert_i,
  input  wire                    occupied_i,
  input  calm_pkg::adc_t         sample_i,
  input  calm_pkg::cell_link_t   left_i,
  output calm_pkg::cell_link_t   right_o
);
  import calm_pkg::*;

  adc_t value_q;
  adc_t value_d;
  logic gt;

  // An empty cell acts as a larger value, so the new word lands no further than the first empty cell.
  assign gt = !occupied_i || (value_q > sample_i);

  assign right_o.gt    = gt;
  assign right_o.value = value_q;

  always_comb begin
    value_d = value_q;
    if (insert_i && gt) begin
      value_d = left_i.gt ? left_i.value : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

@@ src/calm_sort_chain.sv @@
// Row of sorting cells that keeps the stored samples in ascending order.
// Depends on calm_pkg and calm_sort_cell.
`default_nettype none

module calm_sort_chain (
  input  wire              clk_i,
  input  wire              insert_i,
  input  calm_pkg::adc_t   sample_i,
  input  calm_pkg::cnt_t   count_i,
  output calm_pkg::adc_t   median_o
);
  import calm_pkg::*;

  cell_link_t links [SAMPLES+1];

  // The first cell has nothing larger on its left.
  assign links[0].gt    = 1'b0;
  assign links[0].value = sample_i;

  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    calm_sort_cell u_cell (
      .clk_i      (clk_i),
      .insert_i   (insert_i),
      .occupied_i (cnt_t'(i) < count_i),
      .sample_i   (sample_i),
      .left_i     (links[i]),
      .right_o    (links[i+1])
    );
  end

  assign median_o = links[MED_IDX+1].value;

endmodule

`default_nettype wire

@@ src/calm_div_serial.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on calm_pkg.
`default_nettype none

module calm_div_serial (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  calm_pkg::quo_t   dividend_i,
  input  calm_pkg::adc_t   divisor_i,
  output logic             done_o,
  output calm_pkg::quo_t   quotient_o
);
  import calm_pkg::*;

  adc_t              rem_q, rem_d;
  adc_t              dvs_q;
  quo_t              dq_q, dq_d;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic [ADC_BITS:0] trial;
  logic [ADC_BITS:0] diff;
  logic              take;

  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = !diff[ADC_BITS];

  always_comb begin
    rem_d = take ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
    dq_d  = {dq_q[DIV_W-2:0], take};
  end

  assign done_o     = busy_q && (cnt_q == DCNT_W'(1));
  assign quotient_o = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_axis_calibrate_median_center.sv @@
`timescale 1ns / 100ps
// Testbench for axis_calibrate_median_center: random and directed sample words,
// register rewrites between phases, and a scoreboard that predicts each position.
// Depends on calm_pkg, the calm_*_if interfaces and the block itself.

module tb_axis_calibrate_median_center;
  import calm_pkg::*;

  localparam int NUM_ITEMS   = 1675;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    pos_t position;
    logic center_ready;
  } calib_result_t;

  class calib_scoreboard;
    adc_t reg_min, reg_max;
    adc_t trk_min, trk_max, center;
    int unsigned fill_count;
    adc_t store[SAMPLES];
    calib_result_t expected_positions[$];
    int unsigned failures;

    function new();
      reg_min = '0;
      reg_max = adc_t'(4095);
      failures = 0;
      restart();
    endfunction

    function void restart();
      trk_min = reg_min;
      trk_max = reg_max;
      center = '0;
      fill_count = 0;
    endfunction

    // An accepted register write; an unknown index leaves calibration alone.
    function void load_register(cfg_idx_t idx, adc_t val);
      if (idx == REG_INITIAL_MIN) begin
        reg_min = val;
        restart();
      end else if (idx == REG_INITIAL_MAX) begin
        reg_max = val;
        restart();
      end
    endfunction

    function void note_sample(adc_t s);
      adc_t sorted[SAMPLES];
      adc_t v;
      int j;
      int unsigned off, span, pos;
      calib_result_t e;
      if (fill_count < SAMPLES) begin
        store[fill_count] = s;
        fill_count++;
        center = s;
        if (fill_count == SAMPLES) begin
          sorted = store;
          for (int i = 1; i < SAMPLES; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
              sorted[j] = sorted[j-1];
              j--;
            end
            sorted[j] = v;
          end
          center = sorted[MED_IDX];
        end
      end
      // The upper bound is tested first, so a sample on both bounds saturates high.
      if (s >= trk_max) begin
        trk_max = s;
        pos = OUT_MAX;
      end else if (s <= trk_min) begin
        trk_min = s;
        pos = 0;
      end else if (s >= center) begin
        off = s - center;
        span = trk_max - center;
        pos = CENTER + ((span != 0) ? (off * CENTER) / span : 0);
      end else begin
        off = center - s;
        span = center - trk_min;
        pos = CENTER - ((span != 0) ? (off * CENTER) / span : 0);
      end
      e.position = pos_t'(pos);
      e.center_ready = (fill_count == SAMPLES);
      expected_positions.push_back(e);
    endfunction

    function void check_result(pos_t position, logic center_ready);
      calib_result_t e;
      if (expected_positions.size() == 0) begin
        $error("position: no word expected, got %0d", position);
        failures++;
      end else begin
        e = expected_positions.pop_front();
        if (position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, position);
          failures++;
        end
        if (center_ready !== e.center_ready) begin
          $error("center_ready: expected %0b, got %0b", e.center_ready, center_ready);
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_positions.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit steady = 1'b0;
  calib_scoreboard sb = new();

  calm_cfg_if cfg_if();
  calm_in_if  sample_if();
  calm_out_if result_if();

  axis_calibrate_median_center DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      sb.check_result(result_if.position, result_if.center_ready);
  end

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_if.ready <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_sample(adc_t s);
    steady = (sent >= 600 && sent < 900);
    while (!steady && $urandom_range(0, 99) < 9) begin
      sample_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.adc_sample <= s;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    sb.note_sample(s);
    sent++;
    @(negedge clk_i);
  endtask

  // Waits until every result is in, so the block is idle during the write.
  task automatic write_reg(cfg_idx_t idx, adc_t val);
    while (sb.pending() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.load_register(idx, val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    adc_t lo, hi, a, b, s;
    adc_t fill_words[SAMPLES];
    int kind, burst, pick;
    rst_ni = 1'b0;
    sample_if.valid = 1'b0;
    sample_if.adc_sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset bounds: both extremes first, then fill the store so the median is fixed.
    fill_words = '{12'd0, 12'd4095, 12'd2048, 12'd1, 12'd4094, 12'd1500, 12'd2600,
                   12'd2047, 12'd2049, 12'd3000, 12'd900, 12'd3500, 12'd700,
                   12'd2100, 12'd1900, 12'd2200};
    foreach (fill_words[i]) send_sample(fill_words[i]);
    send_sample(12'd1234);
    send_sample(12'd3333);
    sample_if.valid <= 1'b0;

    // Equal bounds: a sample on both bounds must saturate high.
    write_reg(REG_INITIAL_MIN, 12'd2000);
    write_reg(REG_INITIAL_MAX, 12'd2000);
    send_sample(12'd2000);
    send_sample(12'd1999);
    send_sample(12'd2001);
    sample_if.valid <= 1'b0;

    // Inverted bounds.
    write_reg(REG_INITIAL_MIN, 12'd4095);
    write_reg(REG_INITIAL_MAX, 12'd0);
    send_sample(12'd100);
    sample_if.valid <= 1'b0;

    while (sent < NUM_ITEMS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          a = 12'd0;
          b = 12'd4095;
        end
        1: begin
          a = 12'd4095;
          b = 12'd0;
        end
        2: begin
          a = adc_t'($urandom_range(0, 4095));
          b = a;
        end
        3: begin
          a = adc_t'($urandom_range(0, 4090));
          b = a + adc_t'($urandom_range(1, 3));
        end
        default: begin
          a = adc_t'($urandom_range(0, 2000));
          b = adc_t'($urandom_range(int'(a) + 100, 4095));
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg(cfg_idx_t'($urandom_range(2, 255)), adc_t'($urandom_range(0, 4095)));
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) write_reg(REG_INITIAL_MIN, a);
        else write_reg(REG_INITIAL_MAX, b);
      end else if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_INITIAL_MIN, a);
        write_reg(REG_INITIAL_MAX, b);
      end else begin
        write_reg(REG_INITIAL_MAX, b);
        write_reg(REG_INITIAL_MIN, a);
      end

      lo = sb.reg_min;
      hi = sb.reg_max;
      if (lo > hi) begin
        lo = sb.reg_max;
        hi = sb.reg_min;
      end
      // Most bursts run past the fill so the median center gets exercised.
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : $urandom_range(17, 60);
      for (int i = 0; i < burst; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          s = adc_t'($urandom_range(lo, hi));
        end else if (pick < 85) begin
          case ($urandom_range(0, 5))
            0: s = 12'd0;
            1: s = 12'd4095;
            2: s = lo;
            3: s = hi;
            4: s = lo + 12'd1;
            default: s = hi - 12'd1;
          endcase
        end else begin
          s = adc_t'($urandom_range(0, 4095));
        end
        send_sample(s);
      end
      sample_if.valid <= 1'b0;
    end

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ axis_calibrate_median_center.f @@
src/calm_pkg.sv
src/calm_ifs.sv
src/calm_sort_cell.sv
src/calm_sort_chain.sv
src/calm_div_serial.sv
src/axis_calibrate_median_center.sv
sim/tb_axis_calibrate_median_center.sv
